// File: rtl/assert_macros.svh
// Assertion macros for the RTL modules; sspq_ctrl is the one that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define SSPQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define SSPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/sspq_pkg.sv
// Package: types and codes of the stable sorted priority queue.
`default_nettype none
package sspq_pkg;

  localparam int VAL_W = 31;
  localparam int PRI_W = 32;
  localparam int CNT_W = 5;
  localparam int STAT_W = 2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/sspq_req_if.sv
// Request and response channel interfaces.
`default_nettype none
interface sspq_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [sspq_pkg::VAL_W-1:0] item_value;
  logic signed [sspq_pkg::PRI_W-1:0] item_priority;

  modport source (output valid, output req_type, output item_value,
                  output item_priority, input ready);
  modport sink (input valid, input req_type, input item_value,
                input item_priority, output ready);
endinterface

interface sspq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [sspq_pkg::STAT_W-1:0]       status;
  logic [sspq_pkg::VAL_W-1:0]        removed_value;
  logic signed [sspq_pkg::PRI_W-1:0] removed_priority;
  logic [sspq_pkg::CNT_W-1:0]        entry_count;
  logic [sspq_pkg::VAL_W-1:0]        head_value;
  logic [sspq_pkg::VAL_W-1:0]        tail_value;

  modport source (output valid, output status, output removed_value,
                  output removed_priority, output entry_count,
                  output head_value, output tail_value, input ready);
  modport sink (input valid, input status, input removed_value,
                input removed_priority, input entry_count,
                input head_value, input tail_value, output ready);
endinterface
`default_nettype wire

// File: rtl/stable_sorted_priority_queue_top.sv
// Top level of the stable sorted priority queue.
//
//   channel | dir | payload                                         | role
//   req     | in  | req_type, item_value, item_priority             | insert / remove
//   rsp     | out | status, removed_value, removed_priority,        | one per request
//           |     | entry_count, head_value, tail_value             |
//
// Each request is captured in ST_IDLE, then executed in ST_EXEC, in which all
// entries compare against the new priority and shift in parallel.
// The response sits in an output register; a new request is captured while it
// waits, but executes only once the response register is free.
// Synchronous active-high reset empties the store; entry contents are not
// cleared, only the count. No clearing pass is needed.
`default_nettype none
module stable_sorted_priority_queue_top #(
  parameter int QUEUE_DEPTH = 16   // 2 .. 31
) (
  input wire logic   clk,
  input wire logic   rst,
  sspq_req_if.sink   req,
  sspq_rsp_if.source rsp
);

  sspq_pkg::cmd_t  cmd;   // controller -> datapath
  sspq_pkg::stat_t stat;  // datapath -> controller

  // sequencing: capture, execute, hold response until transferred
  sspq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // sorted register store and response payload
  sspq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .req_type         (req.req_type),
    .item_value       (req.item_value),
    .item_priority    (req.item_priority),
    .status           (rsp.status),
    .removed_value    (rsp.removed_value),
    .removed_priority (rsp.removed_priority),
    .entry_count      (rsp.entry_count),
    .head_value       (rsp.head_value),
    .tail_value       (rsp.tail_value)
  );

endmodule
`default_nettype wire

// File: rtl/sspq_ctrl.sv
// Controller: request sequencing and response valid.
`default_nettype none
`include "assert_macros.svh"
module sspq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sspq_pkg::cmd_t       cmd,
  input  wire sspq_pkg::stat_t stat
);

  sspq_pkg::state_t state, state_next;
  logic             out_valid_next;

  always_comb begin
    state_next = state;
    unique case (state)
      sspq_pkg::ST_IDLE: if (in_valid) state_next = sspq_pkg::ST_EXEC;
      sspq_pkg::ST_EXEC: if (!out_valid || out_ready) state_next = sspq_pkg::ST_IDLE;
      default:           state_next = sspq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      sspq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      sspq_pkg::ST_EXEC: begin
        cmd.exec = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sspq_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `SSPQ_ASSERT(a_accept_to_exec, clk, rst, (state == sspq_pkg::ST_IDLE && in_valid) |=> (state == sspq_pkg::ST_EXEC), "accepted request did not start execution")
  `SSPQ_ASSERT(a_rsp_after_exec, clk, rst, $rose(out_valid) |-> $past(cmd.exec), "response valid without an executed request")
  `SSPQ_ASSERT(a_exec_no_overwrite, clk, rst, cmd.exec |-> (!out_valid || out_ready), "pending response overwritten")
  `SSPQ_ASSERT(a_stat_consistent, clk, rst, (state == sspq_pkg::ST_EXEC) |-> !(stat.empty && stat.full), "store reported both empty and full")

endmodule
`default_nettype wire

// File: rtl/sspq_datapath.sv
// Datapath: sorted entry registers with parallel compare-and-shift.
`default_nettype none
module sspq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire sspq_pkg::cmd_t                    cmd,
  output sspq_pkg::stat_t                        stat,
  input  wire logic                              req_type,
  input  wire logic [sspq_pkg::VAL_W-1:0]        item_value,
  input  wire logic signed [sspq_pkg::PRI_W-1:0] item_priority,
  output logic [sspq_pkg::STAT_W-1:0]            status,
  output logic [sspq_pkg::VAL_W-1:0]             removed_value,
  output logic signed [sspq_pkg::PRI_W-1:0]      removed_priority,
  output logic [sspq_pkg::CNT_W-1:0]             entry_count,
  output logic [sspq_pkg::VAL_W-1:0]             head_value,
  output logic [sspq_pkg::VAL_W-1:0]             tail_value
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int VW = sspq_pkg::VAL_W;
  localparam int PW = sspq_pkg::PRI_W;

  // latched request
  logic                 req_remove;
  logic [VW-1:0]        req_val;
  logic signed [PW-1:0] req_pri;

  // entry store, head at index 0
  logic [VW-1:0]        vals [QUEUE_DEPTH];
  logic signed [PW-1:0] pris [QUEUE_DEPTH];
  logic [CW-1:0]        count;
  logic [VW-1:0]        tail;

  logic [VW-1:0]        vals_next [QUEUE_DEPTH];
  logic signed [PW-1:0] pris_next [QUEUE_DEPTH];
  logic [CW-1:0]        count_next;
  logic [VW-1:0]        tail_next;

  logic [QUEUE_DEPTH-1:0] gt;     // held entry with larger priority
  logic [QUEUE_DEPTH-1:0] place;  // slot rewritten by an insert
  logic                   ins_ok, rem_ok;
  logic [CW+sspq_pkg::CNT_W-1:0] cnt_ext;

  logic [sspq_pkg::STAT_W-1:0] status_next;
  logic [VW-1:0]               rem_val_next;
  logic signed [PW-1:0]        rem_pri_next;
  logic [VW-1:0]               head_out, tail_out;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(QUEUE_DEPTH));
  assign ins_ok = (req_remove == sspq_pkg::REQ_INSERT) && !stat.full;
  assign rem_ok = (req_remove == sspq_pkg::REQ_REMOVE) && !stat.empty;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      gt[i]    = (CW'(i) < count) && (pris[i] > req_pri);
      place[i] = gt[i] || (CW'(i) == count);
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      vals_next[i] = vals[i];
      pris_next[i] = pris[i];
    end
    if (ins_ok) begin
      if (place[0]) begin
        vals_next[0] = req_val;
        pris_next[0] = req_pri;
      end
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (place[i]) begin
          if (place[i-1]) begin
            vals_next[i] = vals[i-1];
            pris_next[i] = pris[i-1];
          end else begin
            vals_next[i] = req_val;
            pris_next[i] = req_pri;
          end
        end
      end
    end else if (rem_ok) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        vals_next[i] = vals[i+1];
        pris_next[i] = pris[i+1];
      end
    end
  end

  always_comb begin
    count_next   = count;
    tail_next    = tail;
    status_next  = sspq_pkg::STAT_DONE;
    rem_val_next = '0;
    rem_pri_next = '0;
    if (req_remove == sspq_pkg::REQ_INSERT) begin
      if (ins_ok) begin
        count_next = count + CW'(1);
        if (gt == '0) tail_next = req_val;  // new entry lands at the tail
      end else begin
        status_next = sspq_pkg::STAT_FULL;
      end
    end else begin
      if (rem_ok) begin
        count_next   = count - CW'(1);
        rem_val_next = vals[0];
        rem_pri_next = pris[0];
      end else begin
        status_next = sspq_pkg::STAT_EMPTY;
      end
    end
    head_out = (count_next == '0) ? '0 : vals_next[0];
    tail_out = (count_next == '0) ? '0 : tail_next;
    cnt_ext  = {{sspq_pkg::CNT_W{1'b0}}, count_next};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_remove <= req_type;
      req_val    <= item_value;
      req_pri    <= item_priority;
    end
    if (cmd.exec) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        vals[i] <= vals_next[i];
        pris[i] <= pris_next[i];
      end
      tail             <= tail_next;
      status           <= status_next;
      removed_value    <= rem_val_next;
      removed_priority <= rem_pri_next;
      entry_count      <= cnt_ext[sspq_pkg::CNT_W-1:0];
      head_value       <= head_out;
      tail_value       <= tail_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

endmodule
`default_nettype wire
